@@ design/assert_macros.svh @@
// Assertion macros shared by the DTMF tone generator RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dtmf_pkg.sv @@
// Shared types, constants and key decode for the DTMF tone generator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dtmf_pkg;

  localparam int PHASE_BITS_DEF       = 32;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF      = 16;

  localparam int SAMPLE_RATE_W  = 18;
  localparam int TONE_SAMPLES_W = 20;
  localparam int FREQ_W         = 11;
  localparam int KEY_W          = 8;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 20;

  localparam logic [SAMPLE_RATE_W-1:0]  SAMPLE_RATE_RST  = SAMPLE_RATE_W'(8000);
  localparam logic [TONE_SAMPLES_W-1:0] TONE_SAMPLES_RST = TONE_SAMPLES_W'(4000);

  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_RATE  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TONE_SAMPLES = 1'b1;

  localparam logic [FREQ_W-1:0] ROW_697  = FREQ_W'(697);
  localparam logic [FREQ_W-1:0] ROW_770  = FREQ_W'(770);
  localparam logic [FREQ_W-1:0] ROW_852  = FREQ_W'(852);
  localparam logic [FREQ_W-1:0] ROW_941  = FREQ_W'(941);
  localparam logic [FREQ_W-1:0] COL_1209 = FREQ_W'(1209);
  localparam logic [FREQ_W-1:0] COL_1336 = FREQ_W'(1336);
  localparam logic [FREQ_W-1:0] COL_1477 = FREQ_W'(1477);
  localparam logic [FREQ_W-1:0] COL_1633 = FREQ_W'(1633);

  // pi/2 in Q30 and 1.0 in Q30, for the sine table series
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_READ,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic load_tone;
    logic rom_read;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic div_done;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic              valid;
    logic [FREQ_W-1:0] row;
    logic [FREQ_W-1:0] col;
  } key_tone_t;

  function automatic key_tone_t key_tones(input logic [KEY_W-1:0] key);
    key_tone_t kt;
    kt.valid = 1'b1;
    kt.row   = ROW_697;
    kt.col   = COL_1209;
    case (key)
      8'h31:        begin kt.row = ROW_697; kt.col = COL_1209; end
      8'h32:        begin kt.row = ROW_697; kt.col = COL_1336; end
      8'h33:        begin kt.row = ROW_697; kt.col = COL_1477; end
      8'h41, 8'h61: begin kt.row = ROW_697; kt.col = COL_1633; end
      8'h34:        begin kt.row = ROW_770; kt.col = COL_1209; end
      8'h35:        begin kt.row = ROW_770; kt.col = COL_1336; end
      8'h36:        begin kt.row = ROW_770; kt.col = COL_1477; end
      8'h42, 8'h62: begin kt.row = ROW_770; kt.col = COL_1633; end
      8'h37:        begin kt.row = ROW_852; kt.col = COL_1209; end
      8'h38:        begin kt.row = ROW_852; kt.col = COL_1336; end
      8'h39:        begin kt.row = ROW_852; kt.col = COL_1477; end
      8'h43, 8'h63: begin kt.row = ROW_852; kt.col = COL_1633; end
      8'h2A:        begin kt.row = ROW_941; kt.col = COL_1209; end
      8'h30:        begin kt.row = ROW_941; kt.col = COL_1336; end
      8'h23:        begin kt.row = ROW_941; kt.col = COL_1477; end
      8'h44, 8'h64: begin kt.row = ROW_941; kt.col = COL_1633; end
      default:      kt.valid = 1'b0;
    endcase
    return kt;
  endfunction

endpackage

@@ design/dtmf_tone_generator_core.sv @@
// DTMF tone generator. Each input word is one sample tick and yields exactly one
// output word. A tick with start set maps the ASCII key (0-9, *, #, A-D, either
// case) to a row and a column tone, divides both frequencies into phase steps and
// restarts the burst; an unknown key only raises bad_key. A tick without a valid
// start goes from its accept through the check state to the table read and then
// loads the output register; the next word is accepted after that load. A valid
// start runs the divide between the check and the table read, so its output load
// and the next accept wait for both dividers. The two restoring dividers produce
// one quotient bit per cycle. A full output register that is not drained holds
// the sequencer in its emit state. The next word is taken while a finished word
// waits in the output register. The sine ROM is constant: no init pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtmf_tone_generator_core #(
  parameter int PHASE_BITS       = dtmf_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = dtmf_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = dtmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dtmf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dtmf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dtmf_pkg::KEY_W-1:0]       in_tdata,   // [7:0] key
  input  logic                             in_tuser,   // [0] start_req
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,  // [SAMPLE_BITS-1:0] sample
  output logic [1:0]                       out_tuser,  // [0] active, [1] bad_key
  output logic                             out_tlast
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  dtmf_pkg::dp_cmd_t    dp_cmd;
  dtmf_pkg::dp_status_t dp_sts;

  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          active;
  logic                          bad_key;

  dtmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (dp_sts),
    .cmd       (dp_cmd)
  );

  dtmf_datapath #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .status       (dp_sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_start_req (in_tuser),
    .in_key       (in_tdata),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .out_sample   (sample),
    .out_active   (active),
    .out_last     (out_tlast),
    .out_bad_key  (bad_key)
  );

  assign out_tdata = TDATA_W'($unsigned(sample));
  assign out_tuser = {bad_key, active};

  `ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted a second word back to back")
  `ASSERT_IMPLIES(a_last_in_burst, out_tvalid && out_tlast, out_tuser[0], "last outside a burst")
  `ASSERT_IMPLIES(a_idle_is_zero, out_tvalid && !out_tuser[0], out_tdata == '0, "nonzero idle sample")

endmodule

@@ design/dtmf_divider.sv @@
// Restoring divider: floor(freq * 2^PHASE_BITS / divisor), one quotient bit per cycle.
// Depends on dtmf_pkg for field widths.
`timescale 1ns / 1ps

module dtmf_divider #(
  parameter int PHASE_BITS = dtmf_pkg::PHASE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [dtmf_pkg::FREQ_W-1:0]        freq,
  input  logic [dtmf_pkg::SAMPLE_RATE_W-1:0] divisor,
  output logic                               done,
  output logic [PHASE_BITS-1:0]              quotient
);

  localparam int DW    = dtmf_pkg::SAMPLE_RATE_W;
  localparam int CNT_W = $clog2(PHASE_BITS + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DW-1:0]     rem_r;
  logic [PHASE_BITS-1:0] q_r;
  logic              sat_r;

  logic [DW:0] rem_sh;
  logic [DW:0] rem_sub;
  logic        fits;

  assign rem_sh  = {rem_r, 1'b0};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(PHASE_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient fits only when freq < divisor; otherwise saturate at the end.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DW'(freq);
      q_r   <= '0;
      sat_r <= (divisor == '0) || (DW'(freq) >= divisor);
    end else if (busy_r) begin
      rem_r <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      q_r   <= {q_r[PHASE_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = sat_r ? '1 : q_r;

endmodule

@@ design/dtmf_ctrl.sv @@
// Sequencer for the DTMF tone generator: accepts one tick, runs the divide on a
// valid start, then issues the table read and the output load. Depends on dtmf_pkg.
`timescale 1ns / 1ps

module dtmf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  dtmf_pkg::dp_status_t status,
  output dtmf_pkg::dp_cmd_t    cmd
);

  dtmf_pkg::ctrl_state_t state_r;
  dtmf_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtmf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      dtmf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = dtmf_pkg::ST_CHECK;
        end
      end
      dtmf_pkg::ST_CHECK: begin
        if (status.start_ok) begin
          cmd.div_start = 1'b1;
          state_nxt     = dtmf_pkg::ST_DIVIDE;
        end else begin
          state_nxt = dtmf_pkg::ST_READ;
        end
      end
      dtmf_pkg::ST_DIVIDE: begin
        if (status.div_done) begin
          cmd.load_tone = 1'b1;
          state_nxt     = dtmf_pkg::ST_READ;
        end
      end
      dtmf_pkg::ST_READ: begin
        cmd.rom_read = 1'b1;
        state_nxt    = dtmf_pkg::ST_EMIT;
      end
      dtmf_pkg::ST_EMIT: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = dtmf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dtmf_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ design/dtmf_datapath.sv @@
// Datapath of the DTMF tone generator: config registers, phase accumulators,
// quarter-wave sine ROM, burst counter and output register. Uses dtmf_pkg, dtmf_divider.
`timescale 1ns / 1ps

module dtmf_datapath #(
  parameter int PHASE_BITS       = dtmf_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = dtmf_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = dtmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dtmf_pkg::dp_cmd_t                   cmd,
  output dtmf_pkg::dp_status_t                status,
  input  logic                                cfg_we,
  input  logic [dtmf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dtmf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_start_req,
  input  logic [dtmf_pkg::KEY_W-1:0]          in_key,
  input  logic                                out_tready,
  output logic                                out_valid,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  output logic                                out_active,
  output logic                                out_last,
  output logic                                out_bad_key
);

  localparam int SRW     = dtmf_pkg::SAMPLE_RATE_W;
  localparam int TSW     = dtmf_pkg::TONE_SAMPLES_W;
  localparam int FW      = dtmf_pkg::FREQ_W;
  localparam int QB      = PHASE_BITS - 2;
  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W  = QB + DEPTH_W;
  localparam logic [63:0] ROM_DEN   = 64'(2 * SINE_TABLE_DEPTH);
  localparam logic [63:0] AMPLITUDE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  // Entry i = round(A * sin(pi/2 * (i + 0.5) / depth)) by a Q30 Taylor series.
  function automatic logic [SAMPLE_BITS-1:0] sine_entry(input int i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] sum;
    x    = (dtmf_pkg::HALF_PI_Q30 * (64'(unsigned'(i)) * 64'd2 + 64'd1)) / ROM_DEN;
    x2   = (x * x) >> 30;
    pos  = x;
    term = ((x * x2) >> 30) / 64'd6;
    neg  = term;
    term = ((term * x2) >> 30) / 64'd20;
    pos  = pos + term;
    term = ((term * x2) >> 30) / 64'd42;
    neg  = neg + term;
    term = ((term * x2) >> 30) / 64'd72;
    pos  = pos + term;
    term = ((term * x2) >> 30) / 64'd110;
    neg  = neg + term;
    term = ((term * x2) >> 30) / 64'd156;
    pos  = pos + term;
    term = ((term * x2) >> 30) / 64'd210;
    neg  = neg + term;
    sum  = (pos > neg) ? pos - neg : 64'd0;
    if (sum > dtmf_pkg::ONE_Q30) sum = dtmf_pkg::ONE_Q30;
    return SAMPLE_BITS'((sum * AMPLITUDE + (dtmf_pkg::ONE_Q30 >> 1)) >> 30);
  endfunction

  // Quarter index from the phase, mirrored in odd quadrants.
  function automatic logic [IDX_W-1:0] rom_index(input logic [PHASE_BITS-1:0] ph);
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  idx;
    prod = PROD_W'(ph[QB-1:0]) * PROD_W'(SINE_TABLE_DEPTH);
    idx  = prod[QB +: IDX_W];
    return ph[QB] ? IDX_W'(SINE_TABLE_DEPTH - 1) - idx : idx;
  endfunction

  logic [SAMPLE_BITS-1:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g);
  end

  logic [SRW-1:0]        sample_rate_r;
  logic [TSW-1:0]        tone_samples_r;
  logic                  start_ok_r;
  logic                  bad_r;
  logic [FW-1:0]         row_freq_r;
  logic [FW-1:0]         col_freq_r;
  logic [PHASE_BITS-1:0] row_step_r;
  logic [PHASE_BITS-1:0] col_step_r;
  logic [PHASE_BITS-1:0] row_phase_r;
  logic [PHASE_BITS-1:0] col_phase_r;
  logic [TSW-1:0]        samples_left_r;
  logic [TSW-1:0]        samples_left_nxt;
  logic                  tone_on_r;
  logic [SAMPLE_BITS-1:0] rom_row_r;
  logic [SAMPLE_BITS-1:0] rom_col_r;
  logic                  neg_row_r;
  logic                  neg_col_r;
  logic                  out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic                  out_active_r;
  logic                  out_last_r;
  logic                  out_bad_r;

  dtmf_pkg::key_tone_t   kt;
  logic                  row_done;
  logic                  col_done;
  logic [PHASE_BITS-1:0] row_quot;
  logic [PHASE_BITS-1:0] col_quot;

  logic signed [SAMPLE_BITS:0] row_val;
  logic signed [SAMPLE_BITS:0] col_val;
  logic signed [SAMPLE_BITS:0] sum_val;
  logic signed [SAMPLE_BITS:0] half_val;

  assign kt = dtmf_pkg::key_tones(in_key);

  dtmf_divider #(.PHASE_BITS(PHASE_BITS)) u_div_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .freq     (row_freq_r),
    .divisor  (sample_rate_r),
    .done     (row_done),
    .quotient (row_quot)
  );

  dtmf_divider #(.PHASE_BITS(PHASE_BITS)) u_div_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .freq     (col_freq_r),
    .divisor  (sample_rate_r),
    .done     (col_done),
    .quotient (col_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r  <= dtmf_pkg::SAMPLE_RATE_RST;
      tone_samples_r <= dtmf_pkg::TONE_SAMPLES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dtmf_pkg::CFG_SAMPLE_RATE:  sample_rate_r  <= cfg_data[SRW-1:0];
        dtmf_pkg::CFG_TONE_SAMPLES: tone_samples_r <= cfg_data[TSW-1:0];
        default: ;
      endcase
    end
  end

  // Captured tick: decoded key and start flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_ok_r <= 1'b0;
      bad_r      <= 1'b0;
    end else if (cmd.capture) begin
      start_ok_r <= in_start_req & kt.valid;
      bad_r      <= in_start_req & ~kt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_freq_r <= kt.row;
      col_freq_r <= kt.col;
    end
  end

  assign samples_left_nxt = samples_left_r - TSW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_on_r      <= 1'b0;
      samples_left_r <= '0;
      row_phase_r    <= '0;
      col_phase_r    <= '0;
      row_step_r     <= '0;
      col_step_r     <= '0;
    end else if (cmd.load_tone) begin
      row_step_r     <= row_quot;
      col_step_r     <= col_quot;
      row_phase_r    <= '0;
      col_phase_r    <= '0;
      samples_left_r <= tone_samples_r;
      tone_on_r      <= (tone_samples_r != '0);
    end else if (cmd.emit && tone_on_r) begin
      row_phase_r    <= row_phase_r + row_step_r;
      col_phase_r    <= col_phase_r + col_step_r;
      samples_left_r <= samples_left_nxt;
      if (samples_left_nxt == '0) tone_on_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rom_read) begin
      rom_row_r <= sine_rom[rom_index(row_phase_r)];
      rom_col_r <= sine_rom[rom_index(col_phase_r)];
      neg_row_r <= row_phase_r[PHASE_BITS-1];
      neg_col_r <= col_phase_r[PHASE_BITS-1];
    end
  end

  assign row_val  = neg_row_r ? -$signed({1'b0, rom_row_r}) : $signed({1'b0, rom_row_r});
  assign col_val  = neg_col_r ? -$signed({1'b0, rom_col_r}) : $signed({1'b0, rom_col_r});
  assign sum_val  = row_val + col_val;
  // floor of the mean
  assign half_val = sum_val >>> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample_r <= tone_on_r ? half_val[SAMPLE_BITS-1:0] : '0;
      out_active_r <= tone_on_r;
      out_last_r   <= tone_on_r && (samples_left_nxt == '0);
      out_bad_r    <= bad_r;
    end
  end

  assign status.start_ok = start_ok_r;
  assign status.div_done = row_done & col_done;
  assign status.out_free = ~out_valid_r | out_tready;

  assign out_valid   = out_valid_r;
  assign out_sample  = $signed(out_sample_r);
  assign out_active  = out_active_r;
  assign out_last    = out_last_r;
  assign out_bad_key = out_bad_r;

endmodule
